/* hw/rtl/joystick_differential_drive_mixer_macros.svh */
// Assertion macros for the joystick differential-drive mixer checker.
// No dependencies; included by the checker file.
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_MACROS_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_MACROS_SVH

// Checked on every edge outside reset.
`define JDDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define JDDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/jddm_pkg.sv */
// Shared types, constants and helpers for the joystick differential-drive mixer.
// No dependencies.
`default_nettype none

package jddm_pkg;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_DEAD_ZONE = 2'd0;
  localparam reg_idx_t REG_FAIL_LOW  = 2'd1;
  localparam reg_idx_t REG_FAIL_HIGH = 2'd2;

  typedef logic signed [14:0] coord_t;
  typedef logic signed [16:0] wide_t;
  typedef logic [3:0]         en_t;

  localparam en_t EN_LF = 4'b0001;
  localparam en_t EN_LR = 4'b0010;
  localparam en_t EN_RF = 4'b0100;
  localparam en_t EN_RR = 4'b1000;

  localparam logic [7:0]  DEAD_ZONE_RST = 8'd20;
  localparam logic [11:0] FAIL_LOW_RST  = 12'd900;
  localparam logic [11:0] FAIL_HIGH_RST = 12'd2100;
  localparam logic [11:0] PULSE_CENTER  = 12'd1500;

  localparam logic signed [12:0] PULSE_MIN   = 13'sd1000;
  localparam logic [15:0]        RECIP_10    = 16'd52429;  // 2^19 / 10, rounded up
  localparam coord_t             COORD_SPAN  = 15'sd1550;

  function automatic logic [16:0] mag17(input wide_t v);
    mag17 = v[16] ? 17'(-v) : 17'(v);
  endfunction

  function automatic logic [11:0] sat12(input wide_t v);
    if (v < 17'sd0) begin
      sat12 = 12'd0;
    end else if (v > 17'sd4095) begin
      sat12 = 12'd4095;
    end else begin
      sat12 = v[11:0];
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/jddm_coord.sv */
// Pulse width to signed stick coordinate: (p - 1000) * 31 / 10 - 1550,
// quotient truncated toward zero. Uses jddm_pkg.
`default_nettype none

module jddm_coord
  import jddm_pkg::*;
(
  input  logic [11:0] pulse,
  output coord_t      coord
);

  logic signed [12:0] ofs;
  logic [11:0]        ofs_mag;
  logic [16:0]        scaled;
  logic [32:0]        prod;
  logic [13:0]        quot;
  coord_t             quot_s;
  coord_t             quot_signed;

  assign ofs     = $signed({1'b0, pulse}) - PULSE_MIN;
  assign ofs_mag = ofs[12] ? 12'(-ofs) : ofs[11:0];
  assign scaled  = {ofs_mag, 5'b0} - {5'b0, ofs_mag};
  // divide by 10 through the reciprocal, exact for scaled < 2^18
  assign prod    = 33'(scaled) * 33'(RECIP_10);
  assign quot    = prod[32:19];
  assign quot_s  = $signed({1'b0, quot});
  assign quot_signed = ofs[12] ? -quot_s : quot_s;
  assign coord   = quot_signed - COORD_SPAN;

endmodule

`default_nettype wire

/* hw/rtl/joystick_differential_drive_mixer.sv */
// Pipeline: an accepted input is registered in the coordinate reg, then in the mix reg.
// Throughput: one item per cycle while m_tready holds no item stalled; the coordinate multiply sets the first stage.
// Reset (rst, synchronous): registers back to dead_zone 20, window 900..2100,
// held duties zero and all bridges off; pipeline emptied.
// Depends on jddm_pkg and jddm_coord.
`default_nettype none

module joystick_differential_drive_mixer
  import jddm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  reg_idx_t    cfg_addr,
  input  logic [11:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // pulse_x[11:0], pulse_y[23:12]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // left_duty[11:0], right_duty[23:12], left_fwd[24],
                                 // left_rev[25], right_fwd[26], right_rev[27],
                                 // failsafe_used[28], zero fill[31:29]
);

  logic [7:0]  dead_zone;
  logic [11:0] fail_low;
  logic [11:0] fail_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= DEAD_ZONE_RST;
      fail_low  <= FAIL_LOW_RST;
      fail_high <= FAIL_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEAD_ZONE: dead_zone <= cfg_wdata[7:0];
        REG_FAIL_LOW:  fail_low  <= cfg_wdata;
        REG_FAIL_HIGH: fail_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1: fail-safe window and coordinate map
  logic [11:0] px, py, px_sel, py_sel;
  logic        fs;
  coord_t      cx, cy;

  assign px = s_tdata[11:0];
  assign py = s_tdata[23:12];
  assign fs = (px < fail_low) || (py < fail_low) || (px > fail_high) || (py > fail_high);
  assign px_sel = fs ? PULSE_CENTER : px;
  assign py_sel = fs ? PULSE_CENTER : py;

  jddm_coord u_coord_x (.pulse(px_sel), .coord(cx));
  jddm_coord u_coord_y (.pulse(py_sel), .coord(cy));

  logic   v1, fs1, ready2, load2;
  coord_t x1, y1;

  assign ready2   = !m_tvalid || m_tready;
  assign s_tready = !v1 || ready2;
  assign load2    = v1 && ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      x1  <= cx;
      y1  <= cy;
      fs1 <= fs;
    end
  end

  // stage 2: octant mixing into the held outputs
  wide_t       xe, ye, dyx, sxy;
  logic [16:0] ax, ay;
  logic        dead, hit;
  wide_t       l, r;
  en_t         en;

  assign xe  = 17'(x1);
  assign ye  = 17'(y1);
  assign dyx = ye - xe;
  assign sxy = ye + xe;
  assign ax  = mag17(xe);
  assign ay  = mag17(ye);
  assign dead = (ax < {9'b0, dead_zone}) && (ay < {9'b0, dead_zone});

  always_comb begin
    l   = '0;
    r   = '0;
    en  = '0;
    hit = 1'b1;
    if (dead) begin
      l  = '0;
      r  = '0;
      en = '0;
    end else if (xe < 0 && ye < 0 && xe >= ye) begin
      l = wide_t'(mag17(dyx)); r = wide_t'(ay); en = EN_LR | EN_RR;
    end else if (xe < 0 && ye < 0) begin
      l = wide_t'(mag17(-dyx)); r = wide_t'(mag17(dyx)); en = EN_LR | EN_RF;
    end else if (xe < 0 && ye > 0 && ye >= -xe) begin
      l = sxy; r = ye; en = EN_LF | EN_RF;
    end else if (xe < 0 && ye > 0) begin
      l = wide_t'(mag17(sxy)); r = -xe; en = EN_LR | EN_RF;
    end else if (xe > 0 && ye < 0 && -ye >= xe) begin
      l = wide_t'(ay); r = wide_t'(mag17(sxy)); en = EN_LR | EN_RR;
    end else if (xe > 0 && ye < 0) begin
      l = sxy; r = wide_t'(mag17(sxy)); en = EN_LF | EN_RR;
    end else if (xe > 0 && ye > 0 && ye >= xe) begin
      l = ye; r = dyx; en = EN_LF | EN_RF;
    end else if (xe > 0 && ye > 0) begin
      l = xe; r = wide_t'(mag17(dyx)); en = EN_LF | EN_RR;
    end else begin
      hit = 1'b0;  // an axis exactly zero: keep what is held
    end
  end

  logic [11:0] held_left_duty, held_right_duty;
  en_t         held_enables;
  logic        fs_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid        <= 1'b0;
      held_left_duty  <= '0;
      held_right_duty <= '0;
      held_enables    <= '0;
      fs_out          <= 1'b0;
    end else begin
      if (ready2) begin
        m_tvalid <= v1;
      end
      if (load2) begin
        fs_out <= fs1;
        if (hit) begin
          held_left_duty  <= sat12(l);
          held_right_duty <= sat12(r);
          held_enables    <= en;
        end
      end
    end
  end

  assign m_tdata = {3'b0, fs_out, held_enables, held_right_duty, held_left_duty};

endmodule

`default_nettype wire

/* hw/rtl/jddm_checker.sv */
// Port-level checks for joystick_differential_drive_mixer, bound to the top level.
// Depends on joystick_differential_drive_mixer_macros.svh.
`default_nettype none

`include "joystick_differential_drive_mixer_macros.svh"

module jddm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  logic        stall;
  logic [3:0]  en_o;
  logic [23:0] duty_o;

  assign stall  = m_tvalid && !m_tready;
  assign en_o   = m_tdata[27:24];
  assign duty_o = m_tdata[23:0];

  `JDDM_ASSERT(a_out_hold, stall |=> m_tvalid && $stable(m_tdata), "stalled item changed")
  `JDDM_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")
  `JDDM_ASSERT(a_bridge_safe, m_tvalid |-> !(&en_o[1:0]) && !(&en_o[3:2]), "bridge both ways")
  `JDDM_ASSERT(a_off_zero_duty, m_tvalid && !(|en_o) |-> !(|duty_o), "duty with bridges off")
  `JDDM_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output valid right after reset")

endmodule

bind joystick_differential_drive_mixer jddm_checker u_jddm_checker (
  .clk(clk),
  .rst(rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

`default_nettype wire
